@@ rtl/pwrs_pkg.sv @@
// ----------------------------------------------------------------------------
// pwrs_pkg
// Shared codes, constants and types of the position-weighted residue sampler.
// ----------------------------------------------------------------------------
package pwrs_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_TRAIN  = 2'd0;
  localparam logic [1:0] REQ_END    = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  // command kinds passed from front to back
  localparam logic KIND_COUNT  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int unsigned NUM_RES      = 20;
  localparam int unsigned NUM_CAT      = 21;
  localparam logic [4:0]  TERM_CAT     = 5'd20;
  localparam int unsigned RAND_IN_BITS = 16;
  localparam int unsigned SEQ_LEN_BITS = 12;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic       kind;
    logic [4:0] cat;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ rtl/pwrs_ram.sv @@
// ----------------------------------------------------------------------------
// pwrs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pwrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pwrs_queue.sv @@
// ----------------------------------------------------------------------------
// pwrs_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pwrs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/pwrs_front.sv @@
// ----------------------------------------------------------------------------
// pwrs_front
// Accepts request items, tracks the training position and turns each item
// into a count or sample command for the back part, or drops it.
// ----------------------------------------------------------------------------
module pwrs_front #(
  parameter int unsigned MAX_LEN   = 2048,
  parameter int unsigned RAND_BITS = 16,
  localparam int unsigned PAW = $clog2(MAX_LEN),
  localparam int unsigned RW  = (RAND_BITS < pwrs_pkg::RAND_IN_BITS) ?
                                RAND_BITS : pwrs_pkg::RAND_IN_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [4:0]           residue,
  input  logic                 substitute,
  input  logic [15:0]          random_value,
  input  logic                 q_full,
  input  pwrs_pkg::back_stat_t stat,
  output logic                 q_push,
  output pwrs_pkg::cmd_t       q_cmd,
  output logic [PAW-1:0]       q_pos,
  output logic [RW-1:0]        q_rnd
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = RAND_BITS + 5;

  logic [PW-1:0] train_pos;
  logic [PW-1:0] train_pos_next;
  logic          accept;
  logic          in_range;
  logic [RW-1:0] rnd;
  logic [SW-1:0] scaled;
  logic [4:0]    sub_cat;

  assign in_stall = q_full | stat.clearing;
  assign accept   = in_valid & ~in_stall;
  assign in_range = (train_pos < PW'(MAX_LEN));
  assign rnd      = random_value[RW-1:0];

  // 20*r by shifts, then keep the integer part
  assign scaled  = (SW'(rnd) << 4) + (SW'(rnd) << 2);
  assign sub_cat = 5'(scaled >> RAND_BITS);

  assign q_pos = train_pos[PAW-1:0];
  assign q_rnd = rnd;

  always_comb begin
    q_push         = 1'b0;
    q_cmd.kind     = pwrs_pkg::KIND_COUNT;
    q_cmd.cat      = residue;
    train_pos_next = train_pos;
    if (accept) begin
      unique case (req_type)
        pwrs_pkg::REQ_TRAIN: begin
          if (in_range) begin
            if (substitute) begin
              q_push    = 1'b1;
              q_cmd.cat = sub_cat;
            end else if (residue < 5'(pwrs_pkg::NUM_RES)) begin
              q_push = 1'b1;
            end
            train_pos_next = train_pos + 1'b1;
          end
        end
        pwrs_pkg::REQ_END: begin
          // no terminator row past the last position
          q_push         = in_range;
          q_cmd.cat      = pwrs_pkg::TERM_CAT;
          train_pos_next = '0;
        end
        pwrs_pkg::REQ_SAMPLE: begin
          q_push     = 1'b1;
          q_cmd.kind = pwrs_pkg::KIND_SAMPLE;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      train_pos <= '0;
    end else begin
      train_pos <= train_pos_next;
    end
  end

endmodule

@@ rtl/pwrs_back.sv @@
// ----------------------------------------------------------------------------
// pwrs_back
// Owns the count store: clears it after reset, applies saturating count
// updates and walks a row per sample request below MAX_LEN (roulette wheel).
// ----------------------------------------------------------------------------
module pwrs_back #(
  parameter int unsigned MAX_LEN    = 2048,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned RAND_BITS  = 16,
  localparam int unsigned PAW = $clog2(MAX_LEN),
  localparam int unsigned RW  = (RAND_BITS < pwrs_pkg::RAND_IN_BITS) ?
                                RAND_BITS : pwrs_pkg::RAND_IN_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  pwrs_pkg::cmd_t       q_cmd,
  input  logic [PAW-1:0]       q_pos,
  input  logic [RW-1:0]        q_rnd,
  output logic                 q_pop,
  output pwrs_pkg::back_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           residue_out,
  output logic                 seq_end,
  output logic [11:0]          seq_length
);

  localparam int unsigned PW     = $clog2(MAX_LEN + 1);
  localparam int unsigned CDEPTH = pwrs_pkg::NUM_CAT * MAX_LEN;
  localparam int unsigned CAW    = $clog2(CDEPTH);
  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned HB     = (COUNT_BITS + 1) / 2;
  localparam int unsigned PLW    = HB + RW;
  localparam int unsigned PRW    = COUNT_BITS + RW;
  localparam int unsigned LW     = COUNT_BITS + RAND_BITS;
  localparam logic [CB-1:0] CMAX = '1;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_UPD     = 3'd2;
  localparam logic [2:0] ST_PROD_LO = 3'd3;
  localparam logic [2:0] ST_PROD_HI = 3'd4;
  localparam logic [2:0] ST_WALK    = 3'd5;

  logic [2:0]     state;
  logic [CAW-1:0] clr_addr;
  logic [PW-1:0]  gen_pos;
  logic [CAW-1:0] upd_caddr;
  logic [PAW-1:0] upd_pos;
  logic [CAW-1:0] base_addr;
  logic [RW-1:0]  rnd;
  logic [CB-1:0]  tot;
  logic [PLW-1:0] prod_lo;
  logic [PRW-1:0] rhs;
  logic [CB-1:0]  partial;
  logic [4:0]     acc_cat;
  logic           acc_vld;
  logic [4:0]     cmp_cat;
  logic           cmp_vld;

  logic           cnt_we;
  logic [CAW-1:0] cnt_waddr;
  logic [CB-1:0]  cnt_wdata;
  logic           cnt_re;
  logic [CAW-1:0] cnt_raddr;
  logic [CB-1:0]  cnt_rdata;
  logic           tot_we;
  logic [PAW-1:0] tot_waddr;
  logic [CB-1:0]  tot_wdata;
  logic           tot_re;
  logic [PAW-1:0] tot_raddr;
  logic [CB-1:0]  tot_rdata;

  logic [CB:0]    psum;
  logic [CB-1:0]  part_sat;
  logic [LW-1:0]  lhs;
  logic [LW-1:0]  rhs_sum;
  logic           hit;
  logic           at_end;
  logic           walk_done;
  logic           fin;
  logic [4:0]     fin_pick;
  logic [PAW-1:0] gen_row;

  function automatic logic [CAW-1:0] row_base(input logic [PAW-1:0] pos);
    logic [CAW-1:0] p;
    p = CAW'(pos);
    return (p << 4) + (p << 2) + p;
  endfunction

  assign stat.clearing = (state == ST_CLEAR);
  assign at_end        = (gen_pos == PW'(MAX_LEN));
  assign gen_row       = gen_pos[PAW-1:0];

  // saturating running sum of the row
  assign psum     = {1'b0, cnt_rdata} + {1'b0, partial};
  assign part_sat = psum[CB] ? CMAX : psum[CB-1:0];

  // partial*(2^RAND_BITS-1) >= total*r, rewritten without a multiplier
  assign lhs     = {partial, {RAND_BITS{1'b0}}};
  assign rhs_sum = LW'(rhs) + LW'(partial);
  assign hit     = (lhs >= rhs_sum);

  assign walk_done = cmp_vld && (hit || cmp_cat == pwrs_pkg::TERM_CAT);

  always_comb begin
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_pick  = pwrs_pkg::TERM_CAT;
    cnt_we    = 1'b0;
    cnt_waddr = upd_caddr;
    cnt_wdata = cnt_rdata + 1'b1;
    cnt_re    = 1'b0;
    cnt_raddr = row_base(q_pos) + CAW'(q_cmd.cat);
    tot_we    = 1'b0;
    tot_waddr = upd_pos;
    tot_wdata = tot_rdata + 1'b1;
    tot_re    = 1'b0;
    tot_raddr = q_pos;
    unique case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
        tot_we    = (clr_addr < CAW'(MAX_LEN));
        tot_waddr = clr_addr[PAW-1:0];
        tot_wdata = '0;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == pwrs_pkg::KIND_COUNT) begin
            q_pop  = 1'b1;
            cnt_re = 1'b1;
            tot_re = 1'b1;
          end else if (!out_valid) begin
            q_pop = 1'b1;
            if (at_end) begin
              fin = 1'b1;
            end else begin
              tot_re    = 1'b1;
              tot_raddr = gen_row;
            end
          end
        end
      end
      ST_UPD: begin
        // a saturated count holds, and so does the total with it
        if (cnt_rdata != CMAX) begin
          cnt_we = 1'b1;
          tot_we = (tot_rdata != CMAX);
        end
      end
      ST_PROD_LO: begin
        cnt_re = 1'b0;
      end
      ST_PROD_HI: begin
        cnt_re    = 1'b1;
        cnt_raddr = base_addr;
      end
      ST_WALK: begin
        if (walk_done) begin
          fin      = 1'b1;
          fin_pick = cmp_cat;
        end else if (acc_vld && acc_cat != pwrs_pkg::TERM_CAT) begin
          // fetch ahead; discarded if the compare stage hits
          cnt_re    = 1'b1;
          cnt_raddr = base_addr + CAW'(acc_cat) + 1'b1;
        end
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      gen_pos   <= '0;
      acc_vld   <= 1'b0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fin) begin
        out_valid <= 1'b1;
        if (fin_pick != pwrs_pkg::TERM_CAT) begin
          gen_pos <= gen_pos + 1'b1;
        end else begin
          gen_pos <= '0;
        end
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CAW'(CDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (q_cmd.kind == pwrs_pkg::KIND_COUNT) begin
              state <= ST_UPD;
            end else if (!at_end) begin
              state <= ST_PROD_LO;
            end
          end
        end
        ST_UPD: begin
          state <= ST_IDLE;
        end
        ST_PROD_LO: begin
          state <= ST_PROD_HI;
        end
        ST_PROD_HI: begin
          acc_vld <= 1'b1;
          cmp_vld <= 1'b0;
          state   <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_done) begin
            acc_vld <= 1'b0;
            cmp_vld <= 1'b0;
            state   <= ST_IDLE;
          end else if (acc_vld) begin
            cmp_vld <= 1'b1;
            acc_vld <= (acc_cat != pwrs_pkg::TERM_CAT);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_pop) begin
      upd_caddr <= cnt_raddr;
      upd_pos   <= q_pos;
      base_addr <= row_base(gen_row);
      rnd       <= q_rnd;
    end
    if (state == ST_PROD_LO) begin
      tot     <= tot_rdata;
      prod_lo <= PLW'(tot_rdata[HB-1:0]) * PLW'(rnd);
    end
    if (state == ST_PROD_HI) begin
      rhs     <= PRW'(prod_lo) + ((PRW'(tot[CB-1:HB]) * PRW'(rnd)) << HB);
      partial <= '0;
      acc_cat <= '0;
    end
    if (state == ST_WALK && !walk_done && acc_vld) begin
      partial <= part_sat;
      cmp_cat <= acc_cat;
      acc_cat <= acc_cat + 1'b1;
    end
    if (fin) begin
      if (fin_pick != pwrs_pkg::TERM_CAT) begin
        residue_out <= fin_pick;
        seq_end     <= 1'b0;
        seq_length  <= '0;
      end else begin
        residue_out <= '0;
        seq_end     <= 1'b1;
        seq_length  <= pwrs_pkg::SEQ_LEN_BITS'(gen_pos);
      end
    end
  end

  pwrs_ram #(.WIDTH(CB), .DEPTH(CDEPTH)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pwrs_ram #(.WIDTH(CB), .DEPTH(MAX_LEN)) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .re    (tot_re),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !q_pop && !out_valid)
    else $error("command taken during clearing pass");

  a_fin_into_empty: assert property (@(posedge clk) disable iff (rst)
    fin |-> !out_valid)
    else $error("result produced over a pending result");

  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seq_end |-> residue_out < pwrs_pkg::TERM_CAT)
    else $error("generated residue out of range");

  a_gen_pos_range: assert property (@(posedge clk) disable iff (rst)
    gen_pos <= PW'(MAX_LEN))
    else $error("generation position beyond maximum length");

  a_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    fin && fin_pick == pwrs_pkg::TERM_CAT |=> gen_pos == '0)
    else $error("generation position not cleared after sequence end");

endmodule

@@ rtl/position_weighted_residue_sampler.sv @@
// ----------------------------------------------------------------------------
// A count update holds the back part while it reads and writes back the count
// and total. A sample leaving the queue takes the total*r product, then one
// count read per category, up to 21; a forced end is raised at the edge that
// takes it. No new command is taken until the back part is idle again; the
// front takes items while the queue has room. After reset the count store,
// 21*MAX_LEN entries, is cleared, during which in_stall stays high.
// ----------------------------------------------------------------------------
// position_weighted_residue_sampler
// Learns per-position residue counts and samples sequences from them.
// ----------------------------------------------------------------------------
module position_weighted_residue_sampler #(
  parameter int unsigned MAX_LEN    = 2048,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned RAND_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [4:0]  residue,
  input  logic        substitute,
  input  logic [15:0] random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  residue_out,
  output logic        seq_end,
  output logic [11:0] seq_length
);

  localparam int unsigned PAW = $clog2(MAX_LEN);
  localparam int unsigned RW  = (RAND_BITS < pwrs_pkg::RAND_IN_BITS) ?
                                RAND_BITS : pwrs_pkg::RAND_IN_BITS;
  localparam int unsigned QW  = $bits(pwrs_pkg::cmd_t) + PAW + RW;

  pwrs_pkg::back_stat_t stat;
  pwrs_pkg::cmd_t       f_cmd;
  pwrs_pkg::cmd_t       b_cmd;
  logic [PAW-1:0]       f_pos;
  logic [PAW-1:0]       b_pos;
  logic [RW-1:0]        f_rnd;
  logic [RW-1:0]        b_rnd;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  logic [QW-1:0]        q_dout;

  pwrs_front #(.MAX_LEN(MAX_LEN), .RAND_BITS(RAND_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .residue      (residue),
    .substitute   (substitute),
    .random_value (random_value),
    .q_full       (q_full),
    .stat         (stat),
    .q_push       (q_push),
    .q_cmd        (f_cmd),
    .q_pos        (f_pos),
    .q_rnd        (f_rnd)
  );

  pwrs_queue #(.WIDTH(QW), .DEPTH(pwrs_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_cmd, f_pos, f_rnd}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_cmd, b_pos, b_rnd} = q_dout;

  pwrs_back #(
    .MAX_LEN    (MAX_LEN),
    .COUNT_BITS (COUNT_BITS),
    .RAND_BITS  (RAND_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (b_cmd),
    .q_pos       (b_pos),
    .q_rnd       (b_rnd),
    .q_pop       (q_pop),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .residue_out (residue_out),
    .seq_end     (seq_end),
    .seq_length  (seq_length)
  );

endmodule
